// ===== design/trqs_pkg.sv =====
package trqs_pkg;

	// Number of hardware thread ids and derived widths.
	localparam int MAX_THREADS = 16;
	localparam int TID_W       = $clog2(MAX_THREADS);
	localparam int LEN_W       = $clog2(MAX_THREADS + 1);
	localparam int OUT_TID_W   = 6;
	localparam int COUNT_W     = 7;
	localparam int STATUS_W    = 3;

	typedef logic [TID_W-1:0] tid_t;

	// Request codes.
	localparam logic [1:0] REQ_CREATE = 2'd0;
	localparam logic [1:0] REQ_YIELD  = 2'd1;
	localparam logic [1:0] REQ_KILL   = 2'd2;
	localparam logic [1:0] REQ_EXIT   = 2'd3;

	// Yield kinds.
	localparam logic [1:0] YIELD_NAMED = 2'd0;
	localparam logic [1:0] YIELD_ANY   = 2'd1;
	localparam logic [1:0] YIELD_SELF  = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NONE    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOMORE  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ALLEXIT = 3'd4;

	// Commands broadcast to the queue cells.
	localparam logic [2:0] CELL_IDLE         = 3'd0;
	localparam logic [2:0] CELL_CLEAR        = 3'd1;
	localparam logic [2:0] CELL_MARK         = 3'd2;
	localparam logic [2:0] CELL_APPEND       = 3'd3;
	localparam logic [2:0] CELL_ROTATE       = 3'd4;
	localparam logic [2:0] CELL_SHIFT_ALL    = 3'd5;
	localparam logic [2:0] CELL_SHIFT_MARKED = 3'd6;
	localparam logic [2:0] CELL_PROMOTE      = 3'd7;

	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] yield_kind;
		logic [5:0] target_tid;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [OUT_TID_W-1:0] result_tid;
		logic [OUT_TID_W-1:0] running_tid;
		logic [COUNT_W-1:0]   live_count;
	} rsp_t;

	typedef struct packed {
		logic [2:0] op;
		logic       first;
		logic       tail;
		logic       append;
	} cell_ctl_t;

endpackage

// ===== design/trqs_cell.sv =====
module trqs_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  trqs_pkg::cell_ctl_t ctl,
	input  trqs_pkg::tid_t      load_id,
	input  trqs_pkg::tid_t      head_id,
	input  trqs_pkg::tid_t      next_id,
	input  logic                prev_mark,
	output trqs_pkg::tid_t      id,
	output logic                mark
);

	trqs_pkg::tid_t id_q;
	logic           mark_q;

	// One queue slot. The mark says the target id sits at this slot or an
	// earlier one; it ripples down the row by one slot per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q   <= '0;
			mark_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				trqs_pkg::CELL_IDLE: begin
					id_q <= id_q;
				end
				trqs_pkg::CELL_CLEAR: begin
					mark_q <= 1'b0;
				end
				trqs_pkg::CELL_MARK: begin
					mark_q <= prev_mark | (id_q == load_id);
				end
				trqs_pkg::CELL_APPEND: begin
					if (ctl.append) begin
						id_q <= load_id;
					end
				end
				trqs_pkg::CELL_ROTATE: begin
					if (ctl.tail) begin
						id_q <= head_id;
					end else begin
						id_q <= next_id;
					end
				end
				trqs_pkg::CELL_SHIFT_ALL: begin
					id_q <= next_id;
				end
				trqs_pkg::CELL_SHIFT_MARKED: begin
					if (mark_q) begin
						id_q <= next_id;
					end
				end
				trqs_pkg::CELL_PROMOTE: begin
					if (ctl.first) begin
						id_q <= load_id;
					end else if (ctl.tail) begin
						id_q <= head_id;
					end else if (mark_q) begin
						id_q <= next_id;
					end
				end
				default: begin
					id_q <= id_q;
				end
			endcase
		end
	end

	assign id   = id_q;
	assign mark = mark_q;

endmodule

// ===== design/thread_ready_queue_scheduler_top.sv =====
// Flow: requests that change nothing go straight to the result; rotate and exit pass
// through the apply state; kill and yield to a named id clear the marks, ripple the mark
// down the cell row, then apply; create scans for the lowest free id, one id per cycle.
// Throughput: one request at a time; a new request is taken the cycle after the previous
// result is registered, even while that result waits to be taken.
// Reset: the queue holds thread 0 only, which runs; no result is pending.
module thread_ready_queue_scheduler_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  trqs_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output trqs_pkg::rsp_t rsp
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_CLEAR  = 3'd2;
	localparam logic [2:0] S_MARK   = 3'd3;
	localparam logic [2:0] S_APPLY  = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	localparam logic [1:0] RES_ZERO = 2'd0;
	localparam logic [1:0] RES_LID  = 2'd1;
	localparam logic [1:0] RES_HEAD = 2'd2;

	logic [2:0]                       state_q;
	logic [trqs_pkg::LEN_W-1:0]       len_q;
	logic [trqs_pkg::MAX_THREADS-1:0] live_q;
	trqs_pkg::tid_t                   cnt_q;
	logic                             rsp_valid_q;
	trqs_pkg::rsp_t                   rsp_q;

	logic [2:0]                       op_q;
	trqs_pkg::tid_t                   lid_q;
	logic [trqs_pkg::STATUS_W-1:0]    status_q;
	logic [1:0]                       res_sel_q;

	trqs_pkg::tid_t                   cell_id   [trqs_pkg::MAX_THREADS];
	logic [trqs_pkg::MAX_THREADS-1:0] cell_mark;
	trqs_pkg::cell_ctl_t              cell_ctl  [trqs_pkg::MAX_THREADS];
	logic [2:0]                       cell_op;

	logic [2:0]                       dec_state;
	logic [trqs_pkg::STATUS_W-1:0]    dec_status;
	logic [1:0]                       dec_res;
	logic [2:0]                       dec_op;

	trqs_pkg::tid_t                   head;
	trqs_pkg::tid_t                   tgt_idx;
	logic                             tgt_in_range;
	logic                             tgt_live;
	logic                             tgt_is_head;
	logic                             len_one;
	logic                             accept;
	logic                             out_free;
	trqs_pkg::rsp_t                   rsp_next;

	assign head         = cell_id[0];
	assign tgt_idx      = req.target_tid[trqs_pkg::TID_W-1:0];
	assign tgt_in_range = {1'b0, req.target_tid} < 7'(trqs_pkg::MAX_THREADS);
	assign tgt_live     = tgt_in_range && live_q[tgt_idx];
	assign tgt_is_head  = req.target_tid == trqs_pkg::OUT_TID_W'(head);
	assign len_one      = len_q < trqs_pkg::LEN_W'(2);
	assign req_ready    = state_q == S_IDLE;
	assign accept       = req_valid && req_ready;
	assign out_free     = !rsp_valid_q || rsp_ready;

	// Request decode: checks and choice of the cell sequence.
	always_comb begin
		dec_state  = S_FINISH;
		dec_status = trqs_pkg::ST_OK;
		dec_res    = RES_ZERO;
		dec_op     = trqs_pkg::CELL_IDLE;
		unique case (req.req_type)
			trqs_pkg::REQ_CREATE: begin
				if (len_q >= trqs_pkg::LEN_W'(trqs_pkg::MAX_THREADS)) begin
					dec_status = trqs_pkg::ST_NOMORE;
				end else begin
					dec_state = S_SCAN;
					dec_op    = trqs_pkg::CELL_APPEND;
					dec_res   = RES_LID;
				end
			end
			trqs_pkg::REQ_YIELD: begin
				unique case (req.yield_kind)
					trqs_pkg::YIELD_SELF: begin
						dec_res = RES_HEAD;
					end
					trqs_pkg::YIELD_ANY: begin
						if (len_one) begin
							dec_status = trqs_pkg::ST_NONE;
						end else begin
							dec_state = S_APPLY;
							dec_op    = trqs_pkg::CELL_ROTATE;
							dec_res   = RES_HEAD;
						end
					end
					trqs_pkg::YIELD_NAMED: begin
						if (!tgt_in_range) begin
							dec_status = trqs_pkg::ST_INVALID;
						end else if (tgt_is_head) begin
							dec_res = RES_HEAD;
						end else if (!tgt_live) begin
							dec_status = trqs_pkg::ST_INVALID;
						end else if (len_one) begin
							dec_status = trqs_pkg::ST_NONE;
						end else begin
							dec_state = S_CLEAR;
							dec_op    = trqs_pkg::CELL_PROMOTE;
							dec_res   = RES_HEAD;
						end
					end
					default: begin
						dec_status = trqs_pkg::ST_INVALID;
					end
				endcase
			end
			trqs_pkg::REQ_KILL: begin
				if (req.target_tid == '0 || !tgt_in_range || tgt_is_head || !tgt_live) begin
					dec_status = trqs_pkg::ST_INVALID;
				end else begin
					dec_state = S_CLEAR;
					dec_op    = trqs_pkg::CELL_SHIFT_MARKED;
					dec_res   = RES_LID;
				end
			end
			trqs_pkg::REQ_EXIT: begin
				dec_res = RES_HEAD;
				if (len_one) begin
					dec_status = trqs_pkg::ST_ALLEXIT;
				end else begin
					dec_state = S_APPLY;
					dec_op    = trqs_pkg::CELL_SHIFT_ALL;
				end
			end
			default: begin
				dec_status = trqs_pkg::ST_INVALID;
			end
		endcase
	end

	// Sequencer, queue length, live map and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= trqs_pkg::LEN_W'(1);
			live_q      <= trqs_pkg::MAX_THREADS'(1);
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (req_valid) begin
						state_q <= dec_state;
					end
				end
				S_SCAN: begin
					if (!live_q[cnt_q]) begin
						state_q <= S_APPLY;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_CLEAR: begin
					cnt_q   <= '0;
					state_q <= S_MARK;
				end
				S_MARK: begin
					if (cnt_q == trqs_pkg::TID_W'(trqs_pkg::MAX_THREADS - 1)) begin
						state_q <= S_APPLY;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_APPLY: begin
					state_q <= S_FINISH;
					case (op_q)
						trqs_pkg::CELL_APPEND: begin
							len_q         <= len_q + 1'b1;
							live_q[lid_q] <= 1'b1;
						end
						trqs_pkg::CELL_SHIFT_MARKED: begin
							len_q         <= len_q - 1'b1;
							live_q[lid_q] <= 1'b0;
						end
						trqs_pkg::CELL_SHIFT_ALL: begin
							len_q        <= len_q - 1'b1;
							live_q[head] <= 1'b0;
						end
						default: begin
							len_q <= len_q;
						end
					endcase
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (state_q == S_FINISH && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request payload and result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= dec_op;
			lid_q     <= tgt_idx;
			status_q  <= dec_status;
			res_sel_q <= dec_res;
		end
		if (state_q == S_SCAN && !live_q[cnt_q]) begin
			lid_q <= cnt_q;
		end
		if (state_q == S_FINISH && out_free) begin
			rsp_q <= rsp_next;
		end
	end

	// Result assembly from the state after the request.
	always_comb begin
		rsp_next.status      = status_q;
		rsp_next.running_tid = trqs_pkg::OUT_TID_W'(head);
		rsp_next.live_count  = trqs_pkg::COUNT_W'(len_q);
		case (res_sel_q)
			RES_LID:  rsp_next.result_tid = trqs_pkg::OUT_TID_W'(lid_q);
			RES_HEAD: rsp_next.result_tid = trqs_pkg::OUT_TID_W'(head);
			default:  rsp_next.result_tid = '0;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Command broadcast to the cell row.
	always_comb begin
		unique case (state_q)
			S_CLEAR: cell_op = trqs_pkg::CELL_CLEAR;
			S_MARK:  cell_op = trqs_pkg::CELL_MARK;
			S_APPLY: cell_op = op_q;
			default: cell_op = trqs_pkg::CELL_IDLE;
		endcase
	end

	// Row of queue cells, position 0 is the running thread.
	for (genvar i = 0; i < trqs_pkg::MAX_THREADS; i++) begin : g_cell
		trqs_pkg::tid_t next_id;
		logic           prev_mark;

		if (i == trqs_pkg::MAX_THREADS - 1) begin : g_last
			assign next_id = '0;
		end else begin : g_mid
			assign next_id = cell_id[i + 1];
		end

		if (i == 0) begin : g_first
			assign prev_mark = 1'b0;
		end else begin : g_rest
			assign prev_mark = cell_mark[i - 1];
		end

		assign cell_ctl[i].op     = cell_op;
		assign cell_ctl[i].first  = (i == 0);
		assign cell_ctl[i].tail   = len_q == trqs_pkg::LEN_W'(i + 1);
		assign cell_ctl[i].append = len_q == trqs_pkg::LEN_W'(i);

		trqs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl[i]),
			.load_id   (lid_q),
			.head_id   (head),
			.next_id   (next_id),
			.prev_mark (prev_mark),
			.id        (cell_id[i]),
			.mark      (cell_mark[i])
		);
	end

	// Every queued thread is live and every live thread is queued.
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(live_q) == int'(len_q))
		else $error("live map and queue length disagree");

	// A result beat that waits keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while waiting");

	// The running thread is always live.
	assert property (@(posedge clk) disable iff (!arst_n) live_q[head])
		else $error("running thread is not live");

	// A taken request closes the request channel until it is done.
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> !req_ready)
		else $error("request channel still open after accept");

endmodule
